>>> src/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // Character and attribute codes.
  localparam logic [7:0] SPACE_CHAR    = 8'h20;
  localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [7:0] KEY_RETURN    = 8'h0D;
  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] BLANK_RESET   = 8'h0F;

  // Action codes of an input word.
  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_EXEC       = 3'd2,
    OP_FILL_INIT  = 3'd3,
    OP_FILL_CLEAR = 3'd4,
    OP_SCROLL     = 3'd5
  } tcw_op_e;

  typedef struct packed {
    tcw_op_e op;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic scroll_last;
    logic need_scroll;
    logic is_clear;
    logic out_free;
  } tcw_sts_t;

endpackage

`default_nettype wire

>>> src/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  tcw_pkg::tcw_sts_t sts_i,
  output tcw_pkg::tcw_cmd_t cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = tcw_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = tcw_pkg::OP_FILL_INIT;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tcw_pkg::OP_LOAD;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = tcw_pkg::OP_EXEC;
        priority if (sts_i.is_clear) begin
          state_d = S_FILL;
        end else if (sts_i.need_scroll) begin
          state_d = S_SCROLL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        cmd_o.op = tcw_pkg::OP_FILL_CLEAR;
        if (sts_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd_o.op = tcw_pkg::OP_SCROLL;
        if (sts_i.scroll_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the finished word until the output register is free.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/tcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [7:0]  cfg_wdata_i,
  input  wire        [1:0]  action_i,
  input  wire        [7:0]  char_code_i,
  input  wire        [7:0]  attribute_i,
  input  wire        [10:0] cell_index_i,
  input  wire               out_ready_i,
  output logic              out_valid_o,
  output logic       [7:0]  read_char_o,
  output logic       [7:0]  read_attribute_o,
  output logic       [4:0]  cursor_row_out_o,
  output logic       [6:0]  cursor_col_out_o,
  output logic       [10:0] cursor_offset_o,
  input  tcw_pkg::tcw_cmd_t cmd_i,
  output tcw_pkg::tcw_sts_t sts_o
);

  localparam int CELLS  = ROWS * COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(CELLS + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int RW1    = RW + 1;
  localparam int CLW    = $clog2(COLS);
  localparam int IW     = (AW > 11) ? AW : 11;
  localparam int ROW_OW = (RW > 5) ? RW : 5;
  localparam int COL_OW = (CLW > 7) ? CLW : 7;

  // Item registers.
  logic [1:0]  act_q;
  logic [7:0]  chr_q;
  logic [7:0]  attr_q;
  logic [10:0] idx_q;

  logic [7:0]     blank_q;
  logic [RW-1:0]  row_q, row_d;
  logic [CLW-1:0] col_q, col_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  // Cell store: character in the upper byte, attribute in the lower.
  logic [15:0]    mem_q [CELLS];
  logic [15:0]    rdata_q;
  logic           rd_hit_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [15:0]    mem_wdata;

  logic           out_valid_q;
  logic [7:0]     rchr_q, rattr_q;
  logic [4:0]     orow_q;
  logic [6:0]     ocol_q;
  logic [10:0]    ooff_q;

  logic           is_put, is_clr, is_rd;
  logic           is_nl, is_cr, is_bs, is_prn;
  logic [RW-1:0]  bs_row;
  logic [CLW-1:0] bs_col;
  logic [RW-1:0]  wr_row;
  logic [CLW-1:0] wr_col;
  logic [RW1-1:0] nxt_row;
  logic [CLW-1:0] nxt_col;
  logic           need_scroll;
  logic [AW-1:0]  wr_pos, cur_pos;
  logic [IW-1:0]  idx_ext;
  logic           idx_in_rng;
  logic [CW-1:0]  cnt_m1, rd_src;
  logic [IW-1:0]  off_ext;
  logic [ROW_OW-1:0] row_ext;
  logic [COL_OW-1:0] col_ext;

  always_comb begin
    is_put = (act_q == tcw_pkg::ACT_PUT);
    is_clr = (act_q == tcw_pkg::ACT_CLEAR);
    is_rd  = (act_q == tcw_pkg::ACT_READ);
    is_nl  = (chr_q == tcw_pkg::KEY_NEWLINE);
    is_cr  = (chr_q == tcw_pkg::KEY_RETURN);
    is_bs  = (chr_q == tcw_pkg::KEY_BACKSPACE);
    is_prn = !is_nl && !is_cr && !is_bs;

    // Backspace wraps to the last column of the row above and stops at home.
    priority if (col_q != '0) begin
      bs_row = row_q;
      bs_col = col_q - CLW'(1);
    end else if (row_q != '0) begin
      bs_row = row_q - RW'(1);
      bs_col = CLW'(COLS - 1);
    end else begin
      bs_row = '0;
      bs_col = '0;
    end

    wr_row = is_bs ? bs_row : row_q;
    wr_col = is_bs ? bs_col : col_q;

    priority if (is_nl) begin
      nxt_row = RW1'(row_q) + RW1'(1);
      nxt_col = '0;
    end else if (is_cr) begin
      nxt_row = RW1'(row_q);
      nxt_col = '0;
    end else if (is_bs) begin
      nxt_row = RW1'(bs_row);
      nxt_col = bs_col;
    end else if (col_q == CLW'(COLS - 1)) begin
      nxt_row = RW1'(row_q) + RW1'(1);
      nxt_col = '0;
    end else begin
      nxt_row = RW1'(row_q);
      nxt_col = col_q + CLW'(1);
    end

    need_scroll = is_put && (nxt_row == RW1'(ROWS));

    wr_pos  = AW'(wr_row) * AW'(COLS) + AW'(wr_col);
    cur_pos = AW'(row_q) * AW'(COLS) + AW'(col_q);

    idx_ext    = IW'(idx_q);
    idx_in_rng = (idx_ext < IW'(CELLS));

    cnt_m1 = cnt_q - CW'(1);
    rd_src = cnt_q + CW'(COLS);
  end

  // Memory port and cursor control per operation.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = '0;
    unique case (cmd_i.op)
      tcw_pkg::OP_NONE, tcw_pkg::OP_LOAD: begin
        cnt_d = '0;
      end
      tcw_pkg::OP_EXEC: begin
        if (is_put) begin
          mem_we    = is_bs || is_prn;
          mem_waddr = wr_pos;
          mem_wdata = is_bs ? {tcw_pkg::SPACE_CHAR, attr_q} : {chr_q, attr_q};
          row_d     = need_scroll ? RW'(ROWS - 1) : nxt_row[RW-1:0];
          col_d     = nxt_col;
        end else if (is_clr) begin
          row_d = '0;
          col_d = '0;
        end else if (is_rd) begin
          mem_re    = idx_in_rng;
          mem_raddr = idx_ext[AW-1:0];
        end
      end
      tcw_pkg::OP_FILL_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = {tcw_pkg::SPACE_CHAR, tcw_pkg::BLANK_RESET};
        cnt_d     = cnt_q + CW'(1);
      end
      tcw_pkg::OP_FILL_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = {tcw_pkg::SPACE_CHAR, blank_q};
        cnt_d     = cnt_q + CW'(1);
      end
      tcw_pkg::OP_SCROLL: begin
        // Read one row ahead, and write the cell behind in the following cycle from the registered read data.
        mem_re    = (cnt_q < CW'(CELLS - COLS));
        mem_raddr = rd_src[AW-1:0];
        mem_we    = (cnt_q != '0);
        mem_waddr = cnt_m1[AW-1:0];
        mem_wdata = (cnt_m1 < CW'(CELLS - COLS)) ? rdata_q
                                                 : {tcw_pkg::SPACE_CHAR, blank_q};
        cnt_d     = cnt_q + CW'(1);
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tcw_pkg::OP_LOAD) begin
      act_q  <= action_i;
      chr_q  <= char_code_i;
      attr_q <= attribute_i;
      idx_q  <= cell_index_i;
    end
    if (cmd_i.op == tcw_pkg::OP_EXEC) begin
      rd_hit_q <= is_rd && idx_in_rng;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q     <= tcw_pkg::BLANK_RESET;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blank_q <= cfg_wdata_i;
      end
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    off_ext = IW'(cur_pos);
    row_ext = ROW_OW'(row_q);
    col_ext = COL_OW'(col_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rchr_q  <= rd_hit_q ? rdata_q[15:8] : 8'h00;
      rattr_q <= rd_hit_q ? rdata_q[7:0] : 8'h00;
      orow_q  <= row_ext[4:0];
      ocol_q  <= col_ext[6:0];
      ooff_q  <= off_ext[10:0];
    end
  end

  always_comb begin
    sts_o.fill_last   = (cnt_q == CW'(CELLS - 1));
    sts_o.scroll_last = (cnt_q == CW'(CELLS));
    sts_o.need_scroll = need_scroll;
    sts_o.is_clear    = is_clr;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign read_char_o      = rchr_q;
  assign read_attribute_o = rattr_q;
  assign cursor_row_out_o = orow_q;
  assign cursor_col_out_o = ocol_q;
  assign cursor_offset_o  = ooff_q;

endmodule

`default_nettype wire

>>> src/text_console_writer_core.sv
// An accepted put, read or unused-action word goes through the execute and done states; its
// result is loaded into the output register once that register is free. A put that passes
// the last row adds a scroll sweep, a clear adds a fill sweep. Both use the single cell store.
// A new word is taken only once the previous one is through; its result may still be waiting.
// Reset: asynchronous, active low; afterwards a fill pass writes blank cells over the whole
// store while in_ready_o stays low. Configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: blank color register.
  input  wire         cfg_we_i,
  input  wire  [7:0]  cfg_wdata_i,
  // Input words.
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  action_i,
  input  wire  [7:0]  char_code_i,
  input  wire  [7:0]  attribute_i,
  input  wire  [10:0] cell_index_i,
  // Result words.
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  read_char_o,
  output logic [7:0]  read_attribute_o,
  output logic [4:0]  cursor_row_out_o,
  output logic [6:0]  cursor_col_out_o,
  output logic [10:0] cursor_offset_o
);

  // The controller sequences each word through load, execute and, where
  // needed, a sweep over the cell store (clear fill or scroll copy). The
  // datapath owns the cell store, the cursor, the sweep counter and the
  // output register, so a finished result can wait there while the next
  // word is taken.
  tcw_pkg::tcw_cmd_t cmd;
  tcw_pkg::tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .attribute_i      (attribute_i),
    .cell_index_i     (cell_index_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .read_char_o      (read_char_o),
    .read_attribute_o (read_attribute_o),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_offset_o  (cursor_offset_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

`ifndef SYNTHESIS
  // One word at a time: after an acceptance the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a word is still in progress");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

  // The reported cursor stays on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((32'(cursor_row_out_o) < ROWS) && (32'(cursor_col_out_o) < COLS)))
    else $error("reported cursor outside the screen");
`endif

endmodule

`default_nettype wire
